// ----- design/sorted_table_binary_search_assert.svh -----
// Assertion macros shared by the sorted table search modules.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, ignored during reset
`define STBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, ignored during reset
`define STBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STBS_ASSERT_NOW(label, ante, cons, msg)
`define STBS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- design/stbs_pkg.sv -----
// Shared constants and controller/datapath interface types for the table search.
package stbs_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ENTRY_WIDTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 9;
  localparam int VALUE_W     = 32;

  // Command codes carried on in_tuser
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Source of the next result transaction
  typedef enum logic [1:0] {
    RES_WRITE,
    RES_EMPTY,
    RES_SEARCH
  } stbs_res_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic          write;     // store entry from the input transaction
    logic          start;     // load search bounds and key
    logic          step;      // narrow the range with the probed entry
    logic          load_out;  // load the output register
    stbs_res_sel_t sel;
  } stbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;  // no entries take part in a search
    logic range_done;  // lower and upper bound have met
  } stbs_sts_t;

endpackage

// ----- design/stbs_dpath.sv -----
// Datapath: table memory, search bounds, probe compare and result register.
`include "sorted_table_binary_search_assert.svh"

module stbs_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  stbs_pkg::stbs_cmd_t         cmd,
  output stbs_pkg::stbs_sts_t         sts,
  input  logic                        cfg_valid,
  input  logic [stbs_pkg::CNT_W-1:0]  cfg_data,
  input  logic [stbs_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [stbs_pkg::VALUE_W-1:0] in_item_value,
  output logic                        out_is_search,
  output logic                        out_found,
  output logic [stbs_pkg::IDX_W-1:0]  out_position
);
  import stbs_pkg::*;

  logic signed [ENTRY_WIDTH-1:0] mem [TABLE_DEPTH];

  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_cl;
  logic [IDX_W-1:0]              hi_init;
  logic [IDX_W-1:0]              lo_r, lo_nxt;
  logic [IDX_W-1:0]              hi_r, hi_nxt;
  logic [IDX_W-1:0]              mid_r, mid_nxt;
  logic [IDX_W:0]                mid_sum;
  logic signed [ENTRY_WIDTH-1:0] key_r;
  logic signed [ENTRY_WIDTH-1:0] rd_data_r;
  logic                          key_le;
  logic                          hit;
  logic                          out_is_search_r;
  logic                          out_found_r;
  logic [IDX_W-1:0]              out_position_r;

  // Entry count register, taken straight from the config channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid) begin
      count_r <= cfg_data;
    end
  end

  // Counts beyond the table size use the whole table
  assign count_cl = (count_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_r;
  assign hi_init  = IDX_W'(count_cl - CNT_W'(1));

  // Probe compare on the entry read last cycle (at mid_r)
  assign key_le = (key_r <= rd_data_r);
  assign hit    = (rd_data_r == key_r);

  // Next bounds
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.start) begin
      lo_nxt = '0;
      hi_nxt = hi_init;
    end else if (cmd.step) begin
      if (key_le) begin
        hi_nxt = mid_r;
      end else begin
        lo_nxt = mid_r + IDX_W'(1);
      end
    end
  end

  // Probe address; equals lo once the range has closed
  assign mid_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
  assign mid_nxt = mid_sum[IDX_W:1];

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    if (cmd.start) begin
      key_r <= in_item_value;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[in_entry_index] <= in_item_value;
    end
    rd_data_r <= mem[mid_nxt];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (cmd.sel)
        RES_SEARCH: begin
          out_is_search_r <= 1'b1;
          out_found_r     <= hit;
          out_position_r  <= hit ? lo_r : '0;
        end
        RES_EMPTY: begin
          out_is_search_r <= 1'b1;
          out_found_r     <= 1'b0;
          out_position_r  <= '0;
        end
        default: begin
          out_is_search_r <= 1'b0;
          out_found_r     <= 1'b0;
          out_position_r  <= '0;
        end
      endcase
    end
  end

  assign sts.count_zero = (count_r == '0);
  assign sts.range_done = (lo_r == hi_r);

  assign out_is_search = out_is_search_r;
  assign out_found     = out_found_r;
  assign out_position  = out_position_r;

  `STBS_ASSERT_NOW(a_step_open_range, cmd.step, lo_r < hi_r, "step on a closed range")
  `STBS_ASSERT_NOW(a_mid_in_range, cmd.step, (mid_r >= lo_r) && (mid_r < hi_r), "probe outside range")
  `STBS_ASSERT_NEXT(a_range_shrinks, cmd.step, (hi_r - lo_r) < $past(hi_r - lo_r), "range did not shrink")

endmodule

// ----- design/stbs_ctrl.sv -----
// Controller: handshakes, search sequencing and output register valid.
`include "sorted_table_binary_search_assert.svh"

module stbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_command,
  output logic                out_tvalid,
  input  logic                out_tready,
  output stbs_pkg::stbs_cmd_t cmd,
  input  stbs_pkg::stbs_sts_t sts
);
  import stbs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   accept;

  // Output register can take a result this cycle
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_tvalid && in_tready;

  // Next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.sel      = RES_WRITE;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_WRITE) begin
            cmd.write    = 1'b1;
            cmd.load_out = 1'b1;
            cmd.sel      = RES_WRITE;
          end else if (sts.count_zero) begin
            cmd.load_out = 1'b1;
            cmd.sel      = RES_EMPTY;
          end else begin
            cmd.start = 1'b1;
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (!sts.range_done) begin
          cmd.step = 1'b1;
        end else if (slot_free) begin
          cmd.load_out = 1'b1;
          cmd.sel      = RES_SEARCH;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          cmd.sel      = RES_SEARCH;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the transaction is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `STBS_ASSERT_NOW(a_load_slot_free, cmd.load_out, slot_free, "result overwrites a pending one")
  `STBS_ASSERT_NEXT(a_start_to_search, cmd.start, state_r == ST_SEARCH, "search not entered")
  `STBS_ASSERT_NOW(a_busy_no_accept, state_r != ST_IDLE, !in_tready, "input taken mid-search")

endmodule

// ----- design/sorted_table_binary_search.sv -----
// Top level: sorted table with lower-bound binary search over a stream interface.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  in      | slave     | in_tvalid/tready   | tuser: command; tdata: index, value
//  out     | master    | out_tvalid/tready  | tuser: is_search; tdata: found, position
//  cfg     | slave     | cfg_valid/ready    | cfg_data: entry_count
//
//  A write or empty search reaches the output register the cycle after acceptance.
//  A search over n entries makes one table read per probe on the single read
//  port, plus the final check.
//  rst_n clears the controller and entry_count; table contents are kept.
//  A result held by out_tready blocks the input; the next item is taken once
//  the output register is empty or its transaction completes in the same cycle.
module sorted_table_binary_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] entry_index, [39:8] item_value
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] found, [8:1] position, [15:9] zero
  output logic        out_tuser,  // [0] is_search
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data    // entry_count
);
  import stbs_pkg::*;

  stbs_cmd_t        cmd;
  stbs_sts_t        sts;
  logic             found;
  logic [IDX_W-1:0] position;

  assign cfg_ready = 1'b1;

  stbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  stbs_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .in_entry_index (in_tdata[7:0]),
    .in_item_value  (in_tdata[39:8]),
    .out_is_search  (out_tuser),
    .out_found      (found),
    .out_position   (position)
  );

  // Pack the result transaction
  assign out_tdata = {7'b0, position, found};

endmodule
